FILE: hw/rtl/iteration_gradient_colorizer_top_macros.svh
// Assertion macros shared by the iteration gradient colorizer RTL
`ifndef ITERATION_GRADIENT_COLORIZER_TOP_MACROS_SVH
`define ITERATION_GRADIENT_COLORIZER_TOP_MACROS_SVH
`ifndef SYNTH
`define ICG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ICG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ICG_ASSERT(lbl, prop, msg)
`define ICG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/icg_pkg.sv
// Shared types and constants for the iteration gradient colorizer
`timescale 1ns / 1ps
package icg_pkg;
	localparam int RGB_W       = 24;
	localparam int CHAN_W      = 8;
	localparam int NCH         = RGB_W / CHAN_W;
	localparam int NSEL_W      = 5;   // color count and gradient index width
	localparam int CNT_PORT_W  = 16;
	localparam int PIDX_W      = 4;
	localparam int QUEUE_DEPTH = 32;
	localparam int QAW         = $clog2(QUEUE_DEPTH);

	typedef logic [2:0] status_t;
	localparam status_t ST_OK         = 3'd0;
	localparam status_t ST_COUNT_HIGH = 3'd1;
	localparam status_t ST_NO_COLORS  = 3'd2;
	localparam status_t ST_DEPTH_ZERO = 3'd3;
	localparam status_t ST_TOO_MANY   = 3'd4;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_INNER_COLOR = 2'd0;
	localparam cfg_idx_t CFG_OUTER_COUNT = 2'd1;
	localparam cfg_idx_t CFG_DEPTH       = 2'd2;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_ERROR,
		KIND_INNER,
		KIND_GRAD
	} kind_t;

	// per-item tag that rides along the pipeline
	typedef struct packed {
		kind_t              kind;
		status_t            status;
		logic               wr_en;
		logic [PIDX_W-1:0]  wr_idx;
		logic [RGB_W-1:0]   wr_color;
		logic [RGB_W-1:0]   inner;
		logic [NSEL_W-1:0]  nm1;
	} side_t;
endpackage

FILE: hw/rtl/icg_idx_div.sv
// Pipelined restoring divider for the palette index, one quotient bit per stage
`timescale 1ns / 1ps
module icg_idx_div #(
	parameter int CW = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             vld,
	input  icg_pkg::side_t                   side,
	input  logic [CW+icg_pkg::NSEL_W-1:0]    prod,
	input  logic [CW-1:0]                    divisor,
	output logic                             quo_vld,
	output icg_pkg::side_t                   quo_side,
	output logic [icg_pkg::NSEL_W-1:0]       quo,
	output logic [CW-1:0]                    rem,
	output logic [CW-1:0]                    quo_divisor
);
	import icg_pkg::*;

	localparam int PW = CW + NSEL_W;

	logic              vld_s  [NSEL_W];
	side_t             side_s [NSEL_W];
	logic [PW-1:0]     rem_s  [NSEL_W];
	logic [NSEL_W-1:0] q_s    [NSEL_W];
	logic [CW-1:0]     d_s    [NSEL_W];

	logic [PW-1:0]     rem_in [NSEL_W];
	logic [NSEL_W-1:0] q_in   [NSEL_W];
	logic [CW-1:0]     d_in   [NSEL_W];
	logic [PW-1:0]     shd    [NSEL_W];
	logic              ge     [NSEL_W];
	logic [PW-1:0]     rem_nx [NSEL_W];
	logic [NSEL_W-1:0] q_nx   [NSEL_W];

	always_comb begin
		rem_in[0] = prod;
		q_in[0]   = '0;
		d_in[0]   = divisor;
		for (int i = 1; i < NSEL_W; i++) begin
			rem_in[i] = rem_s[i-1];
			q_in[i]   = q_s[i-1];
			d_in[i]   = d_s[i-1];
		end
		for (int i = 0; i < NSEL_W; i++) begin
			// quotient bits come out MSB first
			shd[i]    = PW'(d_in[i]) << (NSEL_W - 1 - i);
			ge[i]     = rem_in[i] >= shd[i];
			rem_nx[i] = ge[i] ? rem_in[i] - shd[i] : rem_in[i];
			q_nx[i]   = {q_in[i][NSEL_W-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSEL_W; i++)
				vld_s[i] <= 1'b0;
		end else begin
			vld_s[0] <= vld;
			for (int i = 1; i < NSEL_W; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= side;
		for (int i = 1; i < NSEL_W; i++)
			side_s[i] <= side_s[i-1];
		for (int i = 0; i < NSEL_W; i++) begin
			rem_s[i] <= rem_nx[i];
			q_s[i]   <= q_nx[i];
			d_s[i]   <= d_in[i];
		end
	end

	assign quo_vld     = vld_s[NSEL_W-1];
	assign quo_side    = side_s[NSEL_W-1];
	assign quo         = q_s[NSEL_W-1];
	assign rem         = rem_s[NSEL_W-1][CW-1:0];
	assign quo_divisor = d_s[NSEL_W-1];
endmodule

FILE: hw/rtl/icg_palette.sv
// Palette memory: write port for palette items, two registered read ports
`timescale 1ns / 1ps
module icg_palette #(
	parameter int PALETTE_DEPTH = 16,
	parameter int CW            = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld,
	input  icg_pkg::side_t                side,
	input  logic [icg_pkg::NSEL_W-1:0]    quo,
	input  logic [CW-1:0]                 rem,
	input  logic [CW-1:0]                 divisor,
	output logic                          rd_vld,
	output icg_pkg::side_t                rd_side,
	output logic [icg_pkg::RGB_W-1:0]     base_color,
	output logic [icg_pkg::RGB_W-1:0]     next_color,
	output logic [CW-1:0]                 rd_rem,
	output logic [CW-1:0]                 rd_divisor
);
	import icg_pkg::*;

	localparam int AW = $clog2(PALETTE_DEPTH);

	logic [RGB_W-1:0]  mem [PALETTE_DEPTH];
	logic [AW-1:0]     start_addr;
	logic [AW-1:0]     end_addr;
	logic [NSEL_W-1:0] quo_inc;
	logic [AW-1:0]     wr_addr;

	// writes and reads share this stage, so items see the palette in order
	assign quo_inc    = quo + NSEL_W'(1);
	assign start_addr = AW'(quo);
	// last index: stay on the final entry, the remainder is zero there
	assign end_addr   = (quo == side.nm1) ? AW'(quo) : AW'(quo_inc);
	assign wr_addr    = AW'(side.wr_idx);

	always_ff @(posedge clk) begin
		if (vld && side.wr_en)
			mem[wr_addr] <= side.wr_color;
	end

	always_ff @(posedge clk) begin
		base_color  <= mem[start_addr];
		next_color  <= mem[end_addr];
		rd_side     <= side;
		rd_rem      <= rem;
		rd_divisor  <= divisor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_vld <= 1'b0;
		else
			rd_vld <= vld;
	end
endmodule

FILE: hw/rtl/icg_blend.sv
// Per-channel linear blend: r*(end-start)/D floored, one quotient bit per stage
`timescale 1ns / 1ps
module icg_blend #(
	parameter int CW = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld,
	input  icg_pkg::side_t                side,
	input  logic [icg_pkg::RGB_W-1:0]     base_color,
	input  logic [icg_pkg::RGB_W-1:0]     next_color,
	input  logic [CW-1:0]                 rem,
	input  logic [CW-1:0]                 divisor,
	output logic                          mix_vld,
	output icg_pkg::side_t                mix_side,
	output logic [icg_pkg::RGB_W-1:0]     mix_color
);
	import icg_pkg::*;

	localparam int PW = CW + CHAN_W;

	// index 0 holds the product stage, index j the state after j divide steps
	logic              vld_s  [CHAN_W+1];
	side_t             side_s [CHAN_W+1];
	logic [CW-1:0]     d_s    [CHAN_W];
	logic [PW-1:0]     rem_s  [NCH][CHAN_W+1];
	logic [CHAN_W-1:0] q_s    [NCH][CHAN_W];
	logic [CHAN_W-1:0] a_s    [NCH][CHAN_W+1];
	logic              neg_s  [NCH][CHAN_W+1];

	logic [CHAN_W-1:0] a_in   [NCH];
	logic [CHAN_W-1:0] b_in   [NCH];
	logic              neg_in [NCH];
	logic [CHAN_W-1:0] mag_in [NCH];
	logic [CHAN_W-1:0] q_prev [NCH][CHAN_W];
	logic [PW-1:0]     shd    [NCH][CHAN_W];
	logic              ge     [NCH][CHAN_W];
	logic [PW-1:0]     rem_nx [NCH][CHAN_W];
	logic [CHAN_W-1:0] q_nx   [NCH][CHAN_W];
	logic [CHAN_W-1:0] col_nx [NCH];
	logic [CHAN_W-1:0] col_q  [NCH];

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			a_in[c]   = base_color[c*CHAN_W +: CHAN_W];
			b_in[c]   = next_color[c*CHAN_W +: CHAN_W];
			neg_in[c] = b_in[c] < a_in[c];
			mag_in[c] = neg_in[c] ? a_in[c] - b_in[c] : b_in[c] - a_in[c];
			q_prev[c][0] = '0;
			for (int j = 1; j < CHAN_W; j++)
				q_prev[c][j] = q_s[c][j-1];
			for (int j = 0; j < CHAN_W; j++) begin
				shd[c][j]    = PW'(d_s[j]) << (CHAN_W - 1 - j);
				ge[c][j]     = rem_s[c][j] >= shd[c][j];
				rem_nx[c][j] = ge[c][j] ? rem_s[c][j] - shd[c][j] : rem_s[c][j];
				q_nx[c][j]   = {q_prev[c][j][CHAN_W-2:0], ge[c][j]};
			end
			// negative slope: floor means subtract the rounded-up magnitude
			if (neg_s[c][CHAN_W])
				col_nx[c] = a_s[c][CHAN_W] - q_s[c][CHAN_W-1]
					- CHAN_W'(rem_s[c][CHAN_W] != '0);
			else
				col_nx[c] = a_s[c][CHAN_W] + q_s[c][CHAN_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= CHAN_W; j++)
				vld_s[j] <= 1'b0;
			mix_vld <= 1'b0;
		end else begin
			vld_s[0] <= vld;
			for (int j = 1; j <= CHAN_W; j++)
				vld_s[j] <= vld_s[j-1];
			mix_vld <= vld_s[CHAN_W];
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= side;
		for (int j = 1; j <= CHAN_W; j++)
			side_s[j] <= side_s[j-1];
		d_s[0] <= divisor;
		for (int j = 1; j < CHAN_W; j++)
			d_s[j] <= d_s[j-1];
		for (int c = 0; c < NCH; c++) begin
			rem_s[c][0] <= PW'(rem) * PW'(mag_in[c]);
			a_s[c][0]   <= a_in[c];
			neg_s[c][0] <= neg_in[c];
			for (int j = 1; j <= CHAN_W; j++) begin
				rem_s[c][j] <= rem_nx[c][j-1];
				a_s[c][j]   <= a_s[c][j-1];
				neg_s[c][j] <= neg_s[c][j-1];
			end
			for (int j = 0; j < CHAN_W; j++)
				q_s[c][j] <= q_nx[c][j];
			col_q[c] <= col_nx[c];
		end
		mix_side <= side_s[CHAN_W];
	end

	assign mix_color = {col_q[2], col_q[1], col_q[0]};
endmodule

FILE: hw/rtl/iteration_gradient_colorizer_top.sv
// Top level of the iteration gradient colorizer
`timescale 1ns / 1ps
`include "iteration_gradient_colorizer_top_macros.svh"
// Usage:
//  Item channel (item_valid/item_stall): command 0 stores palette_color at
//  palette_index, command 1 colors iteration_count. Every item gives one
//  result (color, status) on the result channel, in order; palette writes
//  answer color 0, status 0.
//  Configuration (cfg_valid/cfg_ready, always ready): index 0 inner color,
//  1 outer color count, 2 iteration depth; other indexes are ignored. Write
//  only while no item is in flight.
//  Pipeline: an accepted item passes two decode/multiply stages, five
//  index-divider stages, the palette read and ten blend stages (product,
//  eight quotient bits, final add). Throughput: one item per cycle while
//  item_stall is low. A 32-entry result queue follows the pipeline;
//  item_stall rises when 32 accepted items are still untaken, so a
//  stalled receiver backs up into the item channel without losing data.
//  Reset: configuration returns to inner 0, one color, depth 256; the
//  pipeline and queue empty. Palette contents are undefined until written.
module iteration_gradient_colorizer_top #(
	parameter int PALETTE_DEPTH = 16,
	parameter int COUNT_BITS    = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic                              command,
	input  logic [icg_pkg::CNT_PORT_W-1:0]    iteration_count,
	input  logic [icg_pkg::PIDX_W-1:0]        palette_index,
	input  logic [icg_pkg::RGB_W-1:0]         palette_color,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [icg_pkg::RGB_W-1:0]         color,
	output icg_pkg::status_t                  status,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  icg_pkg::cfg_idx_t                 cfg_index,
	input  logic [icg_pkg::RGB_W-1:0]         cfg_data
);
	import icg_pkg::*;

	localparam int CW = (COUNT_BITS < CNT_PORT_W) ? COUNT_BITS : CNT_PORT_W;
	localparam int PW = CW + NSEL_W;
	localparam logic [QAW:0] FILL_FULL = (QAW+1)'(QUEUE_DEPTH);

	typedef struct packed {
		logic [RGB_W-1:0] color;
		status_t          status;
	} res_t;

	logic                  item_fire;
	logic                  res_fire;
	logic [RGB_W-1:0]      inner_color_q;
	logic [NSEL_W-1:0]     outer_color_count_q;
	logic [CNT_PORT_W-1:0] iteration_depth_q;

	logic [CW-1:0]         count_m;
	logic [CW-1:0]         depth_m;
	logic                  single;
	side_t                 side_d;
	logic [CW-1:0]         d_d;

	logic                  vld_s1;
	side_t                 side_s1;
	logic [CW-1:0]         count_s1;
	logic [CW-1:0]         d_s1;
	logic                  vld_s2;
	side_t                 side_s2;
	logic [PW-1:0]         prod_s2;
	logic [CW-1:0]         d_s2;

	logic                  div_vld;
	side_t                 div_side;
	logic [NSEL_W-1:0]     div_q;
	logic [CW-1:0]         div_rem;
	logic [CW-1:0]         div_d;
	logic                  pal_vld;
	side_t                 pal_side;
	logic [RGB_W-1:0]      pal_start;
	logic [RGB_W-1:0]      pal_end;
	logic [CW-1:0]         pal_rem;
	logic [CW-1:0]         pal_d;
	logic                  mix_vld;
	side_t                 mix_side;
	logic [RGB_W-1:0]      mix_color;

	res_t                  push_res;
	res_t                  q_mem_q [QUEUE_DEPTH];
	logic [QAW:0]          wr_ptr_q;
	logic [QAW:0]          rd_ptr_q;
	logic [QAW:0]          fill_q;
	logic [QAW:0]          q_used;
	res_t                  head;

	assign item_fire = item_valid && !item_stall;
	assign res_fire  = result_valid && !result_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_color_q       <= '0;
			outer_color_count_q <= NSEL_W'(1);
			iteration_depth_q   <= CNT_PORT_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_INNER_COLOR: inner_color_q       <= cfg_data;
				CFG_OUTER_COUNT: outer_color_count_q <= cfg_data[NSEL_W-1:0];
				CFG_DEPTH:       iteration_depth_q   <= cfg_data[CNT_PORT_W-1:0];
				default: ;
			endcase
		end
	end

	// item decode: writes first, then checks in priority order, then inner, then gradient
	assign count_m = iteration_count[CW-1:0];
	assign depth_m = iteration_depth_q[CW-1:0];
	assign single  = outer_color_count_q == NSEL_W'(1);

	always_comb begin
		side_d.kind     = KIND_GRAD;
		side_d.status   = ST_OK;
		side_d.wr_en    = !command && (32'(palette_index) < PALETTE_DEPTH);
		side_d.wr_idx   = palette_index;
		side_d.wr_color = palette_color;
		side_d.inner    = inner_color_q;
		// a single color runs as index 0 with zero remainder
		side_d.nm1      = single ? '0 : outer_color_count_q - NSEL_W'(1);
		d_d             = single ? CW'(1) : depth_m - CW'(1);
		if (!command) begin
			side_d.kind = KIND_WRITE;
		end else if (count_m > depth_m) begin
			side_d.kind   = KIND_ERROR;
			side_d.status = ST_COUNT_HIGH;
		end else if (outer_color_count_q == '0) begin
			side_d.kind   = KIND_ERROR;
			side_d.status = ST_NO_COLORS;
		end else if (depth_m == '0) begin
			side_d.kind   = KIND_ERROR;
			side_d.status = ST_DEPTH_ZERO;
		end else if ((32'(outer_color_count_q) > 32'(depth_m))
				|| (32'(outer_color_count_q) > PALETTE_DEPTH)) begin
			side_d.kind   = KIND_ERROR;
			side_d.status = ST_TOO_MANY;
		end else if (count_m == depth_m) begin
			side_d.kind = KIND_INNER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= item_fire;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1  <= side_d;
		count_s1 <= count_m;
		d_s1     <= d_d;
		side_s2  <= side_s1;
		prod_s2  <= PW'(count_s1) * PW'(side_s1.nm1);
		d_s2     <= d_s1;
	end

	icg_idx_div #(
		.CW (CW)
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.vld         (vld_s2),
		.side        (side_s2),
		.prod        (prod_s2),
		.divisor     (d_s2),
		.quo_vld     (div_vld),
		.quo_side    (div_side),
		.quo         (div_q),
		.rem         (div_rem),
		.quo_divisor (div_d)
	);

	icg_palette #(
		.PALETTE_DEPTH (PALETTE_DEPTH),
		.CW            (CW)
	) u_pal (
		.clk         (clk),
		.arst_n      (arst_n),
		.vld         (div_vld),
		.side        (div_side),
		.quo         (div_q),
		.rem         (div_rem),
		.divisor     (div_d),
		.rd_vld      (pal_vld),
		.rd_side     (pal_side),
		.base_color  (pal_start),
		.next_color  (pal_end),
		.rd_rem      (pal_rem),
		.rd_divisor  (pal_d)
	);

	icg_blend #(
		.CW (CW)
	) u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.vld         (pal_vld),
		.side        (pal_side),
		.base_color  (pal_start),
		.next_color  (pal_end),
		.rem         (pal_rem),
		.divisor     (pal_d),
		.mix_vld     (mix_vld),
		.mix_side    (mix_side),
		.mix_color   (mix_color)
	);

	always_comb begin
		push_res.status = mix_side.status;
		unique case (mix_side.kind)
			KIND_WRITE: push_res.color = '0;
			KIND_ERROR: push_res.color = '0;
			KIND_INNER: push_res.color = mix_side.inner;
			KIND_GRAD:  push_res.color = mix_color;
			default:    push_res.color = '0;
		endcase
	end

	// result queue; fill_q counts every accepted item not yet taken
	always_ff @(posedge clk) begin
		if (mix_vld)
			q_mem_q[wr_ptr_q[QAW-1:0]] <= push_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (mix_vld)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (res_fire)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (item_fire && !res_fire)
				fill_q <= fill_q + 1'b1;
			else if (!item_fire && res_fire)
				fill_q <= fill_q - 1'b1;
		end
	end

	assign q_used       = wr_ptr_q - rd_ptr_q;
	assign head         = q_mem_q[rd_ptr_q[QAW-1:0]];
	assign result_valid = wr_ptr_q != rd_ptr_q;
	assign color        = head.color;
	assign status       = head.status;
	assign item_stall   = fill_q == FILL_FULL;

	`ICG_ASSERT(a_fill_bound, fill_q <= FILL_FULL, "credit count above queue depth")
	`ICG_ASSERT(a_queue_in_credit, q_used <= fill_q, "queue holds more than accepted")
	`ICG_ASSERT(a_no_overflow, !mix_vld || (q_used != FILL_FULL), "push into full queue")
	`ICG_ASSERT_NEXT(a_fill_inc, item_fire && !res_fire, fill_q == $past(fill_q) + 1, "fill_q missed an item")
	`ICG_ASSERT(a_err_black, !result_valid || (status == ST_OK) || (color == '0), "error result with color")
	`ICG_ASSERT(a_status_range, !result_valid || (status <= ST_TOO_MANY), "bad status code")
endmodule
